// ----- rtl/uad_pkg.sv -----
// Shared types, constants and helpers for the unsigned-to-ASCII digit converter.
// Used by every module under rtl/. No dependencies.
package uad_pkg;

  // Default width of the converted value and depth of the job queue.
  localparam int VALUE_BITS_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Fixed field widths of the channels.
  localparam int IN_VALUE_W = 64;
  localparam int RADIX_W    = 5;
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;
  localparam int CHUNK_W    = 8;

  // Radix limits; a radix outside them saturates.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // Format mode codes.
  localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEX_LO  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX_UP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POINTER = 2'd3;

  // ASCII codes used for prefixes and digits.
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 7'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 7'h58;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;

  // Input item.
  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic [MODE_W-1:0]     format_mode;
    logic                  alt_form;
  } uad_in_t;

  // Result item.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } uad_out_t;

  // Classified job handed from the front end to the converter.
  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic                  upper;
    logic                  prefix;
    logic                  x_upper;
  } uad_job_t;

  // Converter sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PFX_ZERO,
    ST_PFX_X,
    ST_DIGIT
  } uad_state_t;

  // ASCII code of one digit, letters in the requested case.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + CHAR_W'(d);
    end else begin
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      digit_char = base + CHAR_W'(d - 4'd10);
    end
  endfunction

endpackage

// ----- rtl/uad_front.sv -----
// Front end of the digit converter: accepts input items and classifies them.
// Depends on uad_pkg.
module uad_front #(
  parameter int VALUE_BITS = uad_pkg::VALUE_BITS_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  uad_pkg::uad_in_t  in_data,
  input  logic              q_full,
  output logic              q_push,
  output uad_pkg::uad_job_t q_job
);

  logic value_nz;
  logic hex_mode;

  // Accept whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Only the low VALUE_BITS bits take part in the conversion.
  assign value_nz = (in_data.value[VALUE_BITS-1:0] != '0);
  assign hex_mode = (in_data.format_mode == uad_pkg::MODE_HEX_LO) ||
                    (in_data.format_mode == uad_pkg::MODE_HEX_UP);

  // Saturate the radix and decide on the prefix and letter case.
  always_comb begin
    q_job.value = in_data.value;
    if (in_data.radix < uad_pkg::RADIX_MIN) begin
      q_job.radix = uad_pkg::RADIX_MIN;
    end else if (in_data.radix > uad_pkg::RADIX_MAX) begin
      q_job.radix = uad_pkg::RADIX_MAX;
    end else begin
      q_job.radix = in_data.radix;
    end
    q_job.upper   = (in_data.format_mode == uad_pkg::MODE_HEX_UP);
    q_job.x_upper = (in_data.format_mode == uad_pkg::MODE_HEX_UP);
    q_job.prefix  = (in_data.format_mode == uad_pkg::MODE_POINTER) ||
                    (hex_mode && in_data.alt_form && value_nz);
  end

endmodule

// ----- rtl/uad_queue.sv -----
// Small job queue between the front end and the converter.
// Depends on uad_pkg.
module uad_queue #(
  parameter int DEPTH = uad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  uad_pkg::uad_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output uad_pkg::uad_job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uad_pkg::uad_job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/uad_back.sv -----
// Back end of the digit converter: byte-serial division by the radix,
// digit buffer and character output register. Depends on uad_pkg.
module uad_back #(
  parameter int VALUE_BITS = uad_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  uad_pkg::uad_job_t q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output uad_pkg::uad_out_t out_data
);

  localparam int CHUNK_W = uad_pkg::CHUNK_W;
  localparam int NCHUNK  = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int CI_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int NB_W    = $clog2(NCHUNK + 1);
  localparam int DIG_MAX = (VALUE_BITS + 2) / 3;
  localparam int DI_W    = (DIG_MAX > 1) ? $clog2(DIG_MAX) : 1;
  localparam int ND_W    = $clog2(DIG_MAX + 1);
  localparam int PAD_W   = NCHUNK * CHUNK_W;
  localparam int RW      = uad_pkg::RADIX_W;
  localparam int DW      = uad_pkg::DIGIT_W;

  uad_pkg::uad_state_t state_r, state_nxt;

  logic [CHUNK_W-1:0] val_r [NCHUNK];
  logic [DW-1:0]      dig_r [DIG_MAX];
  logic [CI_W-1:0]    idx_r, idx_nxt;
  logic [NB_W-1:0]    nbytes_r, nbytes_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic               nz_r, nz_nxt;
  logic               topz_r, topz_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;
  logic [DI_W-1:0]    rd_r, rd_nxt;
  logic [RW-1:0]      radix_r, radix_nxt;
  logic               upper_r, upper_nxt;
  logic               prefix_r, prefix_nxt;
  logic               xup_r, xup_nxt;
  logic               out_valid_r, out_valid_nxt;
  uad_pkg::uad_out_t  out_data_r, out_data_nxt;

  logic               val_load, val_wr, dig_we;
  logic [PAD_W-1:0]   val_pad;
  logic [CHUNK_W-1:0] chunk, qchunk;
  logic [RW-1:0]      rem_new;
  logic [RW-1:0]      trial;
  logic               out_free;
  logic               q_nonzero;
  logic               shrink;
  logic [NB_W-1:0]    nbytes_dec;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Zero-extended value, split into byte chunks at load.
  assign val_pad = PAD_W'(q_job.value[VALUE_BITS-1:0]);

  // Eight restoring shift-subtract steps on one byte of the dividend.
  assign chunk = val_r[idx_r];
  always_comb begin
    trial  = rem_r;
    qchunk = '0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      trial = {trial[RW-2:0], chunk[b]};
      if (trial >= radix_r) begin
        trial     = trial - radix_r;
        qchunk[b] = 1'b1;
      end
    end
    rem_new = trial;
  end

  assign q_nonzero  = nz_r || (qchunk != '0);
  assign shrink     = (nbytes_r > NB_W'(1)) && topz_r;
  assign nbytes_dec = shrink ? nbytes_r - NB_W'(1) : nbytes_r;

  // Sequencer: next state, datapath control and output register load.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    nbytes_nxt    = nbytes_r;
    rem_nxt       = rem_r;
    nz_nxt        = nz_r;
    topz_nxt      = topz_r;
    nd_nxt        = nd_r;
    rd_nxt        = rd_r;
    radix_nxt     = radix_r;
    upper_nxt     = upper_r;
    prefix_nxt    = prefix_r;
    xup_nxt       = xup_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    val_load      = 1'b0;
    val_wr        = 1'b0;
    dig_we        = 1'b0;
    unique case (state_r)
      uad_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          val_load   = 1'b1;
          idx_nxt    = CI_W'(NCHUNK - 1);
          nbytes_nxt = NB_W'(NCHUNK);
          rem_nxt    = '0;
          nz_nxt     = 1'b0;
          nd_nxt     = '0;
          radix_nxt  = q_job.radix;
          upper_nxt  = q_job.upper;
          prefix_nxt = q_job.prefix;
          xup_nxt    = q_job.x_upper;
          state_nxt  = uad_pkg::ST_DIV;
        end
      end
      uad_pkg::ST_DIV: begin
        val_wr  = 1'b1;
        rem_nxt = rem_new;
        nz_nxt  = q_nonzero;
        if (NB_W'(idx_r) == nbytes_r - NB_W'(1)) begin
          topz_nxt = (qchunk == '0);
        end
        if (idx_r == '0) begin
          // End of one pass: the remainder is the next digit.
          dig_we = 1'b1;
          nd_nxt = nd_r + ND_W'(1);
          if (q_nonzero) begin
            rem_nxt    = '0;
            nz_nxt     = 1'b0;
            nbytes_nxt = nbytes_dec;
            idx_nxt    = CI_W'(nbytes_dec - NB_W'(1));
          end else begin
            rd_nxt    = DI_W'(nd_r);
            state_nxt = prefix_r ? uad_pkg::ST_PFX_ZERO : uad_pkg::ST_DIGIT;
          end
        end else begin
          idx_nxt = idx_r - CI_W'(1);
        end
      end
      uad_pkg::ST_PFX_ZERO: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = uad_pkg::CH_ZERO;
          out_data_nxt.last      = 1'b0;
          state_nxt              = uad_pkg::ST_PFX_X;
        end
      end
      uad_pkg::ST_PFX_X: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = xup_r ? uad_pkg::CH_UPPER_X : uad_pkg::CH_LOWER_X;
          out_data_nxt.last      = 1'b0;
          state_nxt              = uad_pkg::ST_DIGIT;
        end
      end
      uad_pkg::ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = uad_pkg::digit_char(dig_r[rd_r], upper_r);
          out_data_nxt.last      = (rd_r == '0);
          if (rd_r == '0) begin
            state_nxt = uad_pkg::ST_IDLE;
          end else begin
            rd_nxt = rd_r - DI_W'(1);
          end
        end
      end
      default: begin
        state_nxt = uad_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uad_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    nbytes_r   <= nbytes_nxt;
    rem_r      <= rem_nxt;
    nz_r       <= nz_nxt;
    topz_r     <= topz_nxt;
    nd_r       <= nd_nxt;
    rd_r       <= rd_nxt;
    radix_r    <= radix_nxt;
    upper_r    <= upper_nxt;
    prefix_r   <= prefix_nxt;
    xup_r      <= xup_nxt;
    out_data_r <= out_data_nxt;
  end

  // Dividend chunks: loaded whole, then overwritten by quotient bytes.
  always_ff @(posedge clk) begin
    if (val_load) begin
      for (int k = 0; k < NCHUNK; k++) begin
        val_r[k] <= val_pad[k*CHUNK_W +: CHUNK_W];
      end
    end else if (val_wr) begin
      val_r[idx_r] <= qchunk;
    end
  end

  // Digit buffer, least significant digit at index zero.
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[DI_W'(nd_r)] <= rem_new[DW-1:0];
    end
  end

endmodule

// ----- rtl/unsigned_to_ascii_digits.sv -----
// Top level of the unsigned-to-ASCII digit converter.
// Depends on uad_pkg, uad_front, uad_queue and uad_back.
//
// Converts an unsigned value to ASCII characters in a radix of 8 to 16,
// most significant digit first, with an optional "0x"/"0X" prefix, and
// marks the final character with last. A two-entry job queue lets the
// input side take new items while a conversion runs. Each digit is found
// by a byte-serial divider that works one byte at a time through the
// current quotient window. The window starts at ceil(VALUE_BITS/8) bytes
// for every value and drops by at most one byte per digit, once its top
// byte has gone to zero. The characters are then sent one at a time, and
// the next queued job is taken in the cycle after the final character is
// loaded. Even a value below the radix gets a first pass that covers the
// whole window. Output stalls lengthen a conversion; items are converted
// one at a time.
module unsigned_to_ascii_digits #(
  parameter int VALUE_BITS  = uad_pkg::VALUE_BITS_DEF,
  parameter int QUEUE_DEPTH = uad_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uad_pkg::uad_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output uad_pkg::uad_out_t out_data
);

  logic              q_full;
  logic              q_push;
  uad_pkg::uad_job_t push_job;
  logic              q_pop;
  logic              q_valid;
  uad_pkg::uad_job_t pop_job;

  // Accept and classify items.
  uad_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // Decouple the front end from the converter.
  uad_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  // Divide, buffer digits and emit characters.
  uad_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/uad_checker.sv -----
// Port-level checks for the digit converter, bound to the top level.
// Depends on uad_pkg and unsigned_to_ascii_digits.
module uad_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input uad_pkg::uad_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input uad_pkg::uad_out_t out_data
);

  logic              out_xfer;
  logic              prev_zero_r;
  logic              prev_last_r;
  logic              seen_r;
  logic [6:0]        c;

  assign out_xfer = out_valid && out_ready;
  assign c        = out_data.character;

  // Remember the previous transferred character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      prev_zero_r <= 1'b0;
      prev_last_r <= 1'b1;
    end else if (out_xfer) begin
      seen_r      <= 1'b1;
      prev_zero_r <= (c == uad_pkg::CH_ZERO);
      prev_last_r <= out_data.last;
    end
  end

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A waiting input item holds until its transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input item changed");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only digits and prefix letters are produced.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((c >= 7'h30) && (c <= 7'h39)) || ((c >= 7'h61) && (c <= 7'h66)) ||
                  ((c >= 7'h41) && (c <= 7'h46)) || (c == uad_pkg::CH_LOWER_X) ||
                  (c == uad_pkg::CH_UPPER_X))
    else $error("unexpected character");

  // A prefix letter follows a leading zero of the same run and never ends it.
  a_prefix_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && ((c == uad_pkg::CH_LOWER_X) || (c == uad_pkg::CH_UPPER_X)) |->
      seen_r && prev_zero_r && !prev_last_r && !out_data.last)
    else $error("prefix letter out of place");

endmodule

bind unsigned_to_ascii_digits uad_checker u_uad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
